// ===== hdl/ohlcv_pkg.sv =====
package ohlcv_pkg;

  localparam int DEF_SYMBOL_SLOTS = 64;
  localparam int DEF_RING_DEPTH   = 32;

  localparam int FRAMES  = 5;
  localparam int TIME_W  = 48;
  localparam int PRICE_W = 32;
  localparam int SUM_W   = 64;
  localparam int REM_W   = 27;
  localparam int COUNT_W = 6;

  localparam logic [1:0] FUNC_TRADE   = 2'd0;
  localparam logic [1:0] FUNC_SEED    = 2'd1;
  localparam logic [1:0] FUNC_STATS   = 2'd2;
  localparam logic [1:0] FUNC_CANDLES = 2'd3;

  localparam logic [2:0] KIND_STATS  = 3'd0;
  localparam logic [2:0] FRAME_1M    = 3'd0;
  localparam logic [2:0] FRAME_5M    = 3'd1;
  localparam logic [2:0] FRAME_15M   = 3'd2;
  localparam logic [2:0] FRAME_1H    = 3'd3;
  localparam logic [2:0] FRAME_1D    = 3'd4;
  localparam logic [2:0] FRAME_COUNT = 3'd5;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         symbol;
    logic [PRICE_W-1:0] price;
    logic [PRICE_W-1:0] quantity;
    logic [TIME_W-1:0]  trade_time;
    logic [2:0]         timeframe;
    logic [COUNT_W-1:0] count;
  } item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [TIME_W-1:0]  start_time;
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [SUM_W-1:0]   volume;
    logic [SUM_W-1:0]   turnover;
    logic [PRICE_W-1:0] trade_count;
    logic               flag;
    logic               last;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [SUM_W-1:0]   volume;
    logic [SUM_W-1:0]   turnover;
    logic [PRICE_W-1:0] trades;
  } stat_t;

  typedef struct packed {
    logic [TIME_W-1:0]  start_time;
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [SUM_W-1:0]   volume;
    logic [SUM_W-1:0]   turnover;
    logic [PRICE_W-1:0] trades;
  } candle_t;

  localparam stat_t STAT_RESET = '{
    valid: 1'b0, open_price: '0, high_price: '0, low_price: '1,
    close_price: '0, volume: '0, turnover: '0, trades: '0
  };

  typedef struct packed {
    logic load;
    logic clear_we;
    logic stat_rd;
    logic stat_wr_trade;
    logic stat_wr_seed;
    logic emit_stat_query;
    logic div_go;
    logic ring_rd;
    logic cand_rd_last;
    logic cand_wr;
    logic q_setup;
    logic cand_rd_q;
    logic emit_cand_q;
  } dp_cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic       in_range;
    logic [1:0] func;
    logic       tf_ok;
    logic       div_done;
    logic       frame_last;
    logic       n_zero;
    logic       k_last;
  } dp_stat_t;

  function automatic logic [REM_W-1:0] frame_len(input logic [2:0] f);
    unique case (f)
      FRAME_1M:  return REM_W'(60000);
      FRAME_5M:  return REM_W'(300000);
      FRAME_15M: return REM_W'(900000);
      FRAME_1H:  return REM_W'(3600000);
      FRAME_1D:  return REM_W'(86400000);
      default:   return '0;
    endcase
  endfunction

  function automatic result_t stat_result(input stat_t s, input logic flag, input logic last);
    result_t r;
    r.kind        = KIND_STATS;
    r.start_time  = '0;
    r.open_price  = s.open_price;
    r.high_price  = s.high_price;
    r.low_price   = s.low_price;
    r.close_price = s.close_price;
    r.volume      = s.volume;
    r.turnover    = s.turnover;
    r.trade_count = s.trades;
    r.flag        = flag;
    r.last        = last;
    return r;
  endfunction

  function automatic result_t cand_result(input candle_t c, input logic [2:0] frame,
                                          input logic flag, input logic last);
    result_t r;
    r.kind        = frame + 3'd1;
    r.start_time  = c.start_time;
    r.open_price  = c.open_price;
    r.high_price  = c.high_price;
    r.low_price   = c.low_price;
    r.close_price = c.close_price;
    r.volume      = c.volume;
    r.turnover    = c.turnover;
    r.trade_count = c.trades;
    r.flag        = flag;
    r.last        = last;
    return r;
  endfunction

endpackage

// ===== hdl/ohlcv_bucket.sv =====
module ohlcv_bucket (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  go,
  input  logic [ohlcv_pkg::TIME_W-1:0]                          t,
  output logic [ohlcv_pkg::FRAMES-1:0][ohlcv_pkg::REM_W-1:0]    rem,
  output logic                                                  done
);
  import ohlcv_pkg::*;

  localparam int DIG_W  = 8;
  localparam int DIGITS = TIME_W / DIG_W;
  localparam int X_W    = REM_W + DIG_W;
  localparam int RCP_W  = 20;
  localparam int PROD_W = X_W + RCP_W;
  localparam int CNT_W  = $clog2(2 * DIGITS + 1);

  // Reciprocals scaled by 2**X_W and rounded down, so a quotient digit
  // estimate is never high and at most one low.
  function automatic logic [RCP_W-1:0] frame_recip(input logic [2:0] f);
    unique case (f)
      FRAME_1M:  return RCP_W'(572662);
      FRAME_5M:  return RCP_W'(114532);
      FRAME_15M: return RCP_W'(38177);
      FRAME_1H:  return RCP_W'(9544);
      FRAME_1D:  return RCP_W'(397);
      default:   return '0;
    endcase
  endfunction

  logic [TIME_W-1:0]              t_sh;
  logic [CNT_W-1:0]               cnt;
  logic                           running;
  logic [FRAMES-1:0][PROD_W-1:0]  prod, prod_next;
  logic [FRAMES-1:0][REM_W-1:0]   rem_next;

  // One byte of time per step for all five frame lengths side by side: the
  // reciprocal product first, then the remainder with a single correction.
  always_comb begin
    logic [X_W-1:0]   x;
    logic [DIG_W-1:0] q_est;
    logic [X_W-1:0]   r_est;
    prod_next = prod;
    rem_next  = rem;
    for (int f = 0; f < FRAMES; f++) begin
      x            = {rem[f], t_sh[TIME_W-1 -: DIG_W]};
      prod_next[f] = PROD_W'(x) * PROD_W'(frame_recip(3'(f)));
      q_est        = prod[f][X_W +: DIG_W];
      r_est        = x - X_W'(q_est) * X_W'(frame_len(3'(f)));
      if (r_est >= X_W'(frame_len(3'(f)))) begin
        rem_next[f] = REM_W'(r_est - X_W'(frame_len(3'(f))));
      end else begin
        rem_next[f] = REM_W'(r_est);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (go) begin
      running <= 1'b1;
      cnt     <= CNT_W'(2 * DIGITS);
    end else if (running) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        running <= 1'b0;
      end
    end
  end

  // Even counts form the products, odd counts fold in one byte of time.
  always_ff @(posedge clk) begin
    if (go) begin
      t_sh <= t;
      rem  <= '0;
    end else if (running) begin
      if (cnt[0]) begin
        t_sh <= {t_sh[TIME_W-DIG_W-1:0], DIG_W'(0)};
        rem  <= rem_next;
      end else begin
        prod <= prod_next;
      end
    end
  end

  assign done = !running;

endmodule

// ===== hdl/ohlcv_ctrl.sv =====
module ohlcv_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ohlcv_pkg::dp_stat_t   sts,
  output ohlcv_pkg::dp_cmd_t    cmd,
  output logic                  busy
);
  import ohlcv_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_DECODE = 14'b00000000000100,
    S_TSTAT  = 14'b00000000001000,
    S_TWAIT  = 14'b00000000010000,
    S_TRRD   = 14'b00000000100000,
    S_TCRD   = 14'b00000001000000,
    S_TCWR   = 14'b00000010000000,
    S_SEED   = 14'b00000100000000,
    S_QSTAT  = 14'b00001000000000,
    S_QSETUP = 14'b00010000000000,
    S_QCHK   = 14'b00100000000000,
    S_QRD    = 14'b01000000000000,
    S_QOUT   = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.in_range) begin
          state_next = S_IDLE;
        end else begin
          unique case (sts.func)
            FUNC_TRADE: begin
              cmd.stat_rd = 1'b1;
              cmd.div_go  = 1'b1;
              state_next  = S_TSTAT;
            end
            FUNC_SEED: begin
              cmd.stat_rd = 1'b1;
              state_next  = S_SEED;
            end
            FUNC_STATS: begin
              cmd.stat_rd = 1'b1;
              state_next  = S_QSTAT;
            end
            default: begin
              if (sts.tf_ok) begin
                cmd.ring_rd = 1'b1;
                state_next  = S_QSETUP;
              end else begin
                state_next = S_IDLE;
              end
            end
          endcase
        end
      end
      S_TSTAT: begin
        cmd.stat_wr_trade = 1'b1;
        state_next        = S_TWAIT;
      end
      S_TWAIT: begin
        if (sts.div_done) begin
          state_next = S_TRRD;
        end
      end
      S_TRRD: begin
        cmd.ring_rd = 1'b1;
        state_next  = S_TCRD;
      end
      S_TCRD: begin
        cmd.cand_rd_last = 1'b1;
        state_next       = S_TCWR;
      end
      S_TCWR: begin
        cmd.cand_wr = 1'b1;
        state_next  = sts.frame_last ? S_IDLE : S_TRRD;
      end
      S_SEED: begin
        cmd.stat_wr_seed = 1'b1;
        state_next       = S_IDLE;
      end
      S_QSTAT: begin
        cmd.emit_stat_query = 1'b1;
        state_next          = S_IDLE;
      end
      S_QSETUP: begin
        cmd.q_setup = 1'b1;
        state_next  = S_QCHK;
      end
      S_QCHK: begin
        state_next = sts.n_zero ? S_IDLE : S_QRD;
      end
      S_QRD: begin
        cmd.cand_rd_q = 1'b1;
        state_next    = S_QOUT;
      end
      S_QOUT: begin
        cmd.emit_cand_q = 1'b1;
        state_next      = sts.k_last ? S_IDLE : S_QRD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hdl/ohlcv_dp.sv =====
module ohlcv_dp #(
  parameter int SYMBOL_SLOTS = ohlcv_pkg::DEF_SYMBOL_SLOTS,
  parameter int RING_DEPTH   = ohlcv_pkg::DEF_RING_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ohlcv_pkg::dp_cmd_t   cmd,
  input  ohlcv_pkg::item_t     item,
  output ohlcv_pkg::dp_stat_t  sts,
  output logic                 strobe,
  output ohlcv_pkg::result_t   result
);
  import ohlcv_pkg::*;

  localparam int SLOT_W  = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
  localparam int RINGS   = SYMBOL_SLOTS * FRAMES;
  localparam int RB_W    = $clog2(RINGS);
  localparam int POS_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W  = $clog2(RING_DEPTH + 1);
  localparam int S_W     = FILL_W + 1;
  localparam int RING_W  = FILL_W + POS_W;
  localparam int CANDLES = RINGS * RING_DEPTH;
  localparam int CA_W    = $clog2(CANDLES);
  localparam int CMP_W   = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;

  function automatic logic [POS_W-1:0] wrap(input logic [S_W-1:0] v);
    if (v >= S_W'(RING_DEPTH)) begin
      return POS_W'(v - S_W'(RING_DEPTH));
    end
    return POS_W'(v);
  endfunction

  stat_t              stat_mem [SYMBOL_SLOTS];
  logic [RING_W-1:0]  ring_mem [RINGS];
  candle_t            cand_mem [CANDLES];

  item_t              item_q;
  logic [SUM_W-1:0]   pq;
  logic [2:0]         fr;
  logic [RB_W-1:0]    clr_idx;
  stat_t              stat_rd;
  logic [RING_W-1:0]  ring_rd;
  candle_t            cand_rd;
  logic [FILL_W-1:0]  qn, qfirst, qk;
  result_t            result_q;
  logic               strobe_q;

  logic [FRAMES-1:0][REM_W-1:0] rem;
  logic               div_done;

  logic [SLOT_W-1:0]  slot;
  logic [2:0]         frame_sel;
  logic [RB_W-1:0]    rb;
  logic [CA_W-1:0]    cand_base;
  logic [FILL_W-1:0]  fill_r;
  logic [POS_W-1:0]   head_r;
  logic [POS_W-1:0]   pos_last, pos_q, pos_new;
  logic [FILL_W-1:0]  fill_n, q_n;
  logic [POS_W-1:0]   head_n;
  logic [TIME_W-1:0]  bucket;
  logic               opened;
  candle_t            cand_upd;
  stat_t              st_trade, st_seed;
  logic               k_last;

  logic               stat_we;
  logic [SLOT_W-1:0]  stat_wa;
  stat_t              stat_wd;
  logic               ring_we;
  logic [RB_W-1:0]    ring_wa;
  logic [RING_W-1:0]  ring_wd;

  ohlcv_bucket u_bucket (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .t    (item_q.trade_time),
    .rem  (rem),
    .done (div_done)
  );

  always_comb begin
    slot      = SLOT_W'(item_q.symbol);
    frame_sel = (item_q.func == FUNC_CANDLES) ? item_q.timeframe : fr;
    rb        = RB_W'(slot) * RB_W'(FRAMES) + RB_W'(frame_sel);
    cand_base = CA_W'(rb) * CA_W'(RING_DEPTH);
    fill_r    = ring_rd[RING_W-1:POS_W];
    head_r    = ring_rd[POS_W-1:0];
    pos_last  = wrap(S_W'(head_r) + S_W'(fill_r) - S_W'(1));
    pos_q     = wrap(S_W'(head_r) + S_W'(qfirst) + S_W'(qk));
    bucket    = item_q.trade_time - TIME_W'(rem[fr]);
    k_last    = (FILL_W'(qk + FILL_W'(1)) == qn);
    q_n       = (CMP_W'(item_q.count) < CMP_W'(fill_r)) ? FILL_W'(item_q.count) : fill_r;

    // A trade opens a new candle on an empty ring or when its bucket moved on.
    opened   = (fill_r == '0) || (cand_rd.start_time != bucket);
    fill_n   = fill_r;
    head_n   = head_r;
    pos_new  = pos_last;
    cand_upd = cand_rd;
    if (opened) begin
      if (fill_r < FILL_W'(RING_DEPTH)) begin
        pos_new = wrap(S_W'(head_r) + S_W'(fill_r));
        fill_n  = fill_r + FILL_W'(1);
      end else begin
        pos_new = head_r;
        head_n  = wrap(S_W'(head_r) + S_W'(1));
      end
      cand_upd.start_time  = bucket;
      cand_upd.open_price  = item_q.price;
      cand_upd.high_price  = item_q.price;
      cand_upd.low_price   = item_q.price;
      cand_upd.volume      = '0;
      cand_upd.turnover    = '0;
      cand_upd.trades      = '0;
    end
    if (item_q.price > cand_upd.high_price) begin
      cand_upd.high_price = item_q.price;
    end
    if (item_q.price < cand_upd.low_price) begin
      cand_upd.low_price = item_q.price;
    end
    cand_upd.close_price = item_q.price;
    cand_upd.volume      = cand_upd.volume + SUM_W'(item_q.quantity);
    cand_upd.turnover    = cand_upd.turnover + pq;
    cand_upd.trades      = cand_upd.trades + PRICE_W'(1);

    st_trade       = stat_rd;
    st_trade.valid = 1'b1;
    if (stat_rd.open_price == '0) begin
      st_trade.open_price = item_q.price;
    end
    if (item_q.price > stat_rd.high_price) begin
      st_trade.high_price = item_q.price;
    end
    if (item_q.price < stat_rd.low_price) begin
      st_trade.low_price = item_q.price;
    end
    st_trade.close_price = item_q.price;
    st_trade.volume      = stat_rd.volume + SUM_W'(item_q.quantity);
    st_trade.turnover    = stat_rd.turnover + pq;
    st_trade.trades      = stat_rd.trades + PRICE_W'(1);

    st_seed             = stat_rd;
    st_seed.valid       = 1'b1;
    st_seed.open_price  = item_q.price;
    st_seed.high_price  = item_q.price;
    st_seed.low_price   = item_q.price;
    st_seed.close_price = item_q.price;

    stat_we = (cmd.clear_we && (clr_idx < RB_W'(SYMBOL_SLOTS)))
              || cmd.stat_wr_trade || cmd.stat_wr_seed;
    stat_wa = cmd.clear_we ? clr_idx[SLOT_W-1:0] : slot;
    stat_wd = cmd.clear_we ? STAT_RESET : (cmd.stat_wr_seed ? st_seed : st_trade);

    ring_we = cmd.clear_we || cmd.cand_wr;
    ring_wa = cmd.clear_we ? clr_idx : rb;
    ring_wd = cmd.clear_we ? '0 : {fill_n, head_n};
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[stat_wa] <= stat_wd;
    end
    if (cmd.stat_rd) begin
      stat_rd <= stat_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    if (cmd.ring_rd) begin
      ring_rd <= ring_mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_wr) begin
      cand_mem[cand_base + CA_W'(pos_new)] <= cand_upd;
    end
    if (cmd.cand_rd_last) begin
      cand_rd <= cand_mem[cand_base + CA_W'(pos_last)];
    end else if (cmd.cand_rd_q) begin
      cand_rd <= cand_mem[cand_base + CA_W'(pos_q)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    pq <= SUM_W'(item_q.price) * SUM_W'(item_q.quantity);
    if (cmd.q_setup) begin
      qn     <= q_n;
      qfirst <= fill_r - q_n;
    end
    if (cmd.stat_wr_trade) begin
      result_q <= stat_result(st_trade, 1'b1, 1'b0);
    end else if (cmd.emit_stat_query) begin
      result_q <= stat_result(stat_rd, stat_rd.valid, 1'b1);
    end else if (cmd.cand_wr) begin
      result_q <= cand_result(cand_upd, fr, opened, fr == FRAME_1D);
    end else if (cmd.emit_cand_q) begin
      result_q <= cand_result(cand_rd, item_q.timeframe, 1'b0, k_last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      fr       <= '0;
      qk       <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd.stat_wr_trade || cmd.emit_stat_query || cmd.cand_wr
                  || cmd.emit_cand_q;
      if (cmd.clear_we) begin
        clr_idx <= clr_idx + RB_W'(1);
      end
      if (cmd.load) begin
        fr <= FRAME_1M;
      end else if (cmd.cand_wr) begin
        fr <= fr + 3'd1;
      end
      if (cmd.q_setup) begin
        qk <= '0;
      end else if (cmd.emit_cand_q) begin
        qk <= qk + FILL_W'(1);
      end
    end
  end

  always_comb begin
    sts.clear_last = (clr_idx == RB_W'(RINGS - 1));
    sts.in_range   = (int'(item_q.symbol) < SYMBOL_SLOTS);
    sts.func       = item_q.func;
    sts.tf_ok      = (item_q.timeframe < FRAME_COUNT);
    sts.div_done   = div_done;
    sts.frame_last = (fr == FRAME_1D);
    sts.n_zero     = (qn == '0);
    sts.k_last     = k_last;
  end

  assign strobe = strobe_q;
  assign result = result_q;

`ifndef SYNTH
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe_q && result_q.last |=> !strobe_q)
    else $error("word strobed right after the final word of an item");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> (ring_wd[RING_W-1:POS_W] <= FILL_W'(RING_DEPTH)))
    else $error("ring fill written beyond ring depth");

  a_bucket_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.cand_wr |-> div_done)
    else $error("candle written before bucket remainders were ready");
`endif

endmodule

// ===== hdl/ohlcv_candle_aggregator_core.sv =====
// Trade: six words from accept to the last; the bucket remainder unit first runs
// six byte steps, each a product step then a remainder step, then the frames go in turn.
// A candle query returns n words; for n of zero it returns none.
// Results come one word per strobe; the receiver cannot stall, so none wait.
// Synchronous reset, then a clearing pass over all 5 * SYMBOL_SLOTS rings with busy high.
module ohlcv_candle_aggregator_core #(
  parameter int SYMBOL_SLOTS = ohlcv_pkg::DEF_SYMBOL_SLOTS,
  parameter int RING_DEPTH   = ohlcv_pkg::DEF_RING_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ohlcv_pkg::item_t    item,
  output logic                strobe,
  output ohlcv_pkg::result_t  result
);
  import ohlcv_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t sts;

  ohlcv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ohlcv_dp #(
    .SYMBOL_SLOTS (SYMBOL_SLOTS),
    .RING_DEPTH   (RING_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .sts    (sts),
    .strobe (strobe),
    .result (result)
  );

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ohlcv_pkg::*;

  localparam int SLOTS = DEF_SYMBOL_SLOTS;
  localparam int DEPTH = DEF_RING_DEPTH;
  localparam int NRING = SLOTS * FRAMES;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    strobe;
  result_t result;

  ohlcv_candle_aggregator_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .strobe(strobe), .result(result)
  );

  always #2 clk = ~clk;

  // Shadow copy of the per-symbol totals and the candle rings.
  stat_t       sym_stat [SLOTS];
  int unsigned ring_cnt [NRING];
  int unsigned ring_top [NRING];
  candle_t     candles  [NRING][DEPTH];

  item_t   pending[$];
  result_t owed[$];
  int      errors = 0;
  int      send_idle = 0;
  bit      hold_off = 1'b0;

  task automatic queue_item(item_t it);
    pending = {pending, it};
  endtask

  task automatic expect_word(result_t r);
    owed = {owed, r};
  endtask

  function automatic logic [47:0] frame_ms(int f);
    case (f)
      0: return 48'd60000;
      1: return 48'd300000;
      2: return 48'd900000;
      3: return 48'd3600000;
      default: return 48'd86400000;
    endcase
  endfunction

  function automatic result_t candle_word(candle_t c, int f, bit fl, bit lst);
    result_t r;
    r.kind = 3'(f + 1);
    r.start_time = c.start_time;
    r.open_price = c.open_price;
    r.high_price = c.high_price;
    r.low_price = c.low_price;
    r.close_price = c.close_price;
    r.volume = c.volume;
    r.turnover = c.turnover;
    r.trade_count = c.trades;
    r.flag = fl;
    r.last = lst;
    return r;
  endfunction

  function automatic result_t stat_word(int s, bit fl);
    result_t r;
    r.kind = KIND_STATS;
    r.start_time = '0;
    r.open_price = sym_stat[s].open_price;
    r.high_price = sym_stat[s].high_price;
    r.low_price = sym_stat[s].low_price;
    r.close_price = sym_stat[s].close_price;
    r.volume = sym_stat[s].volume;
    r.turnover = sym_stat[s].turnover;
    r.trade_count = sym_stat[s].trades;
    r.flag = fl;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic aggregate(item_t it);
    int s;
    int rb;
    int pos;
    int n;
    bit opened;
    logic [47:0] bucket;
    logic [63:0] pq;
    result_t r;
    s = int'(it.symbol);
    if (s >= SLOTS) return;
    pq = 64'(it.price) * 64'(it.quantity);
    case (it.func)
      FUNC_TRADE: begin
        sym_stat[s].valid = 1'b1;
        if (sym_stat[s].open_price == 0) sym_stat[s].open_price = it.price;
        if (it.price > sym_stat[s].high_price) sym_stat[s].high_price = it.price;
        if (it.price < sym_stat[s].low_price) sym_stat[s].low_price = it.price;
        sym_stat[s].close_price = it.price;
        sym_stat[s].volume += 64'(it.quantity);
        sym_stat[s].turnover += pq;
        sym_stat[s].trades += 1;
        expect_word(stat_word(s, 1'b1));
        for (int f = 0; f < FRAMES; f++) begin
          rb = s * FRAMES + f;
          bucket = (it.trade_time / frame_ms(f)) * frame_ms(f);
          opened = 1'b1;
          if (ring_cnt[rb] != 0) begin
            pos = (ring_top[rb] + ring_cnt[rb] - 1) % DEPTH;
            opened = candles[rb][pos].start_time != bucket;
          end
          if (opened) begin
            if (ring_cnt[rb] < DEPTH) begin
              pos = (ring_top[rb] + ring_cnt[rb]) % DEPTH;
              ring_cnt[rb]++;
            end else begin
              pos = ring_top[rb];
              ring_top[rb] = (ring_top[rb] + 1) % DEPTH;
            end
            candles[rb][pos] = '{bucket, it.price, it.price, it.price, it.price,
                                 64'd0, 64'd0, 32'd0};
          end
          if (it.price > candles[rb][pos].high_price) candles[rb][pos].high_price = it.price;
          if (it.price < candles[rb][pos].low_price) candles[rb][pos].low_price = it.price;
          candles[rb][pos].close_price = it.price;
          candles[rb][pos].volume += 64'(it.quantity);
          candles[rb][pos].turnover += pq;
          candles[rb][pos].trades += 1;
          expect_word(candle_word(candles[rb][pos], f, opened, f == FRAMES - 1));
        end
      end
      FUNC_SEED: begin
        sym_stat[s].valid = 1'b1;
        sym_stat[s].open_price = it.price;
        sym_stat[s].high_price = it.price;
        sym_stat[s].low_price = it.price;
        sym_stat[s].close_price = it.price;
      end
      FUNC_STATS: begin
        r = stat_word(s, sym_stat[s].valid);
        r.last = 1'b1;
        expect_word(r);
      end
      default: begin
        if (it.timeframe < FRAMES) begin
          rb = s * FRAMES + int'(it.timeframe);
          n = (it.count < ring_cnt[rb]) ? int'(it.count) : ring_cnt[rb];
          for (int k = 0; k < n; k++) begin
            pos = (ring_top[rb] + ring_cnt[rb] - n + k) % DEPTH;
            expect_word(candle_word(candles[rb][pos], int'(it.timeframe), 1'b0,
                                    k == n - 1));
          end
        end
      end
    endcase
  endtask

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Driver: a word is taken at an edge with start high and busy low.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) aggregate(item);
      if (start && busy) begin
        // Word still waiting; keep it up.
      end else if (pending.size() != 0 && !hold_off &&
                   $urandom_range(99) >= send_idle) begin
        item <= pending[0];
        pending.delete(0);
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      if (owed.size() == 0) begin
        report("word with nothing expected");
      end else begin
        want = owed[0];
        owed.delete(0);
        if (result.kind != want.kind) report("kind");
        if (result.start_time != want.start_time) report("start_time");
        if (result.open_price != want.open_price) report("open_price");
        if (result.high_price != want.high_price) report("high_price");
        if (result.low_price != want.low_price) report("low_price");
        if (result.close_price != want.close_price) report("close_price");
        if (result.volume != want.volume) report("volume");
        if (result.turnover != want.turnover) report("turnover");
        if (result.trade_count != want.trade_count) report("trade_count");
        if (result.flag != want.flag) report("flag");
        if (result.last != want.last) report("last");
      end
    end
  end

  function automatic item_t mk(logic [1:0] fn, int sym, logic [31:0] p, logic [31:0] q,
                               logic [47:0] t, int tf, int cnt);
    item_t it;
    it.func = fn;
    it.symbol = 6'(sym);
    it.price = p;
    it.quantity = q;
    it.trade_time = t;
    it.timeframe = 3'(tf);
    it.count = 6'(cnt);
    return it;
  endfunction

  function automatic item_t random_item(int sym, logic [47:0] t);
    int sel;
    item_t it;
    sel = $urandom_range(99);
    it = mk(FUNC_TRADE, sym, $urandom, $urandom, t, 0, 0);
    if ($urandom_range(3) == 0) it.price = $urandom_range(1000, 1);
    if ($urandom_range(3) == 0) it.quantity = $urandom_range(100);
    it.timeframe = 3'($urandom_range(7));
    it.count = 6'($urandom_range(63));
    if (sel >= 95) it.func = FUNC_SEED;
    else if (sel >= 85) it.func = FUNC_STATS;
    else if (sel >= 72) begin
      it.func = FUNC_CANDLES;
      if ($urandom_range(4) != 0) it.timeframe = 3'($urandom_range(4));
      if ($urandom_range(2) != 0) it.count = 6'($urandom_range(6));
    end
    return it;
  endfunction

  task automatic drain();
    wait (pending.size() == 0 && !start);
    while (owed.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    logic [47:0] clock_ms [4];
    int sym;
    for (int s = 0; s < SLOTS; s++) sym_stat[s] = STAT_RESET;
    for (int r = 0; r < NRING; r++) begin
      ring_cnt[r] = 0;
      ring_top[r] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queries, extremes, seeds, rollover of buckets and ring.
    queue_item(mk(FUNC_STATS, 63, 0, 0, 0, 0, 0));
    queue_item(mk(FUNC_CANDLES, 0, 0, 0, 0, 0, 32));
    queue_item(mk(FUNC_TRADE, 0, '1, '1, '1, 0, 0));
    queue_item(mk(FUNC_TRADE, 0, 0, '1, '1, 0, 0));
    queue_item(mk(FUNC_TRADE, 0, 32'd5, 32'd7, 48'd59999, 0, 0));
    queue_item(mk(FUNC_TRADE, 0, 32'd9, 32'd1, 48'd60000, 0, 0));
    queue_item(mk(FUNC_STATS, 0, 0, 0, 0, 0, 0));
    queue_item(mk(FUNC_SEED, 1, 32'd77, 0, 0, 0, 0));
    queue_item(mk(FUNC_STATS, 1, 0, 0, 0, 0, 0));
    queue_item(mk(FUNC_TRADE, 1, 32'd80, 32'd3, 48'd86400000, 0, 0));
    queue_item(mk(FUNC_CANDLES, 0, 0, 0, 0, 0, 0));
    queue_item(mk(FUNC_CANDLES, 0, 0, 0, 0, 5, 4));
    queue_item(mk(FUNC_CANDLES, 0, 0, 0, 0, 7, 4));
    queue_item(mk(FUNC_CANDLES, 0, 0, 0, 0, 0, 63));
    queue_item(mk(FUNC_CANDLES, 0, 0, 0, 0, 4, 1));
    // Fill one 1m ring past its depth so the oldest candle is evicted.
    for (int i = 0; i < 34; i++)
      queue_item(mk(FUNC_TRADE, 2, 32'(100 + i), 32'd2, 48'(i * 60000), 0, 0));
    queue_item(mk(FUNC_CANDLES, 2, 0, 0, 0, int'(FRAME_1M), 32));
    queue_item(mk(FUNC_CANDLES, 2, 0, 0, 0, int'(FRAME_5M), 3));
    drain();

    // Random phases: per-symbol trade clocks move forward, mostly in small steps.
    for (int i = 0; i < 4; i++) clock_ms[i] = 48'($urandom_range(100000)) * 1000;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 54 : ((ph == 3) ? 36 : 0);
      for (int n = 0; n < 45; n++) begin
        sym = $urandom_range(3);
        if ($urandom_range(9) == 0) sym = $urandom_range(63);
        if (sym < 4) begin
          clock_ms[sym] += $urandom_range(9) < 6 ? 48'($urandom_range(30000))
                                                 : 48'($urandom_range(5000000));
          queue_item(random_item(sym, clock_ms[sym]));
        end else begin
          queue_item(random_item(sym, 48'({$urandom, $urandom})));
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Partway through the directed items, hold the sender back until every
  // owed word has come.
  initial begin
    wait (!rst);
    wait (pending.size() > 30);
    wait (pending.size() == 30);
    hold_off = 1'b1;
    wait (!start);
    while (owed.size() != 0) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #3ms;
    $display("Verification failed");
    $finish;
  end
endmodule
